// File: hw/rtl/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// shared types and constants of the table linear interpolator
// ----------------------------------------------------------------------------
package tli_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_W = 24;
    localparam int VAL_W = 32;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [1:0] MODE_ZERO = 2'd0;
    localparam logic [1:0] MODE_EDGE = 2'd1;

    // memory port select for the datapath address mux
    typedef enum logic [2:0] {
        AS_LOAD_SCAN = 3'd0,
        AS_SHIFT     = 3'd1,
        AS_FIRST     = 3'd2,
        AS_LAST      = 3'd3,
        AS_MID       = 3'd4,
        AS_LO        = 3'd5,
        AS_LOM1      = 3'd6
    } addr_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic      latch_in;
        addr_sel_t asel;
        logic      rd;
        logic      wr_shift;
        logic      wr_new;
        logic      dec_pos;
        logic      cnt_clear;
        logic      cnt_inc;
        logic      bs_init;
        logic      bs_step;
        logic      cap_first;
        logic      cap_last;
        logic      cap_hi;
        logic      cap_lo;
        logic      div_start;
        logic      emit_zero;
        logic      emit_full;
        logic      emit_empty;
        logic      emit_first;
        logic      emit_last;
        logic      emit_interp;
    } tli_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic pos_zero;
        logic scan_gt;
        logic bs_done;
        logic q_le_first;
        logic q_ge_last;
        logic div_done;
    } tli_sts_t;

endpackage

// File: hw/rtl/tli_div.sv
// ----------------------------------------------------------------------------
// tli_div
// restoring divider, one quotient bit per cycle, 56 by 24 bits
// ----------------------------------------------------------------------------
module tli_div
    import tli_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [55:0] dividend,
    input  logic [23:0] divisor,
    output logic        done,
    output logic [55:0] quotient
);

    logic [55:0] quo_reg, quo_next;
    logic [24:0] rem_reg, rem_next;
    logic [23:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        act_reg, act_next;
    logic [24:0] trial;

    // operand load on start, else one shift and subtract step
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        act_next = act_reg;
        trial = {rem_reg[23:0], quo_reg[55]};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = 6'd0;
            act_next = 1'b1;
        end
        else if (act_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial - {1'b0, dsr_reg};
                quo_next = {quo_reg[54:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[54:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd55)
                act_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            act_reg <= act_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = act_reg && (cnt_reg == 6'd55);
    assign quotient = {quo_next[55:0]};

endmodule

// File: hw/rtl/tli_datapath.sv
// ----------------------------------------------------------------------------
// tli_datapath
// key and value memories, search registers, interpolation arithmetic
// ----------------------------------------------------------------------------
module tli_datapath
    import tli_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  tli_cmd_t           cmd,
    input  logic [1:0]         extrap_mode,
    input  logic [KEY_W-1:0]   in_key,
    input  logic [VAL_W-1:0]   in_val,
    output tli_sts_t           sts,
    output logic               res_valid,
    output logic [VAL_W-1:0]   res_value,
    output logic               res_oor,
    output logic [1:0]         res_status
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic [VAL_W-1:0] val_mem [TABLE_DEPTH];

    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    pos_reg;
    logic [CW-1:0]    lo_reg, hi_reg;
    logic [KEY_W-1:0] q_reg, rd_key_reg, x0_reg, x1_reg;
    logic [VAL_W-1:0] v_reg, rd_val_reg, y0_reg, y1_reg;
    logic [KEY_W-1:0] kf_reg, kl_reg;
    logic [VAL_W-1:0] vf_reg, vl_reg;
    logic             neg_reg;
    logic [55:0]      prod_reg;
    logic [CW-1:0]    mid;
    logic [CW-1:0]    addr_full;
    logic [AW-1:0]    addr;
    logic             div_done;
    logic [55:0]      quotient;
    logic [32:0]      dy;
    logic [32:0]      dy_mag;
    logic             out_lo, out_hi;
    logic             rv_reg;
    logic [VAL_W-1:0] rval_reg;
    logic             roor_reg;
    logic [1:0]       rst_reg;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // address select
    always_comb
    begin
        case (cmd.asel)
            AS_LOAD_SCAN: addr_full = pos_reg - CW'(1);
            AS_SHIFT:     addr_full = pos_reg;
            AS_FIRST:     addr_full = '0;
            AS_LAST:      addr_full = count_reg - CW'(1);
            AS_MID:       addr_full = mid;
            AS_LO:        addr_full = lo_reg;
            AS_LOM1:      addr_full = lo_reg - CW'(1);
            default:      addr_full = '0;
        endcase
    end
    assign addr = addr_full[AW-1:0];

    // memories: shift writes the entry read last cycle one place up
    always_ff @(posedge clk)
    begin
        if (cmd.wr_shift)
        begin
            key_mem[addr] <= rd_key_reg;
            val_mem[addr] <= rd_val_reg;
        end
        else if (cmd.wr_new)
        begin
            key_mem[addr] <= q_reg;
            val_mem[addr] <= v_reg;
        end
        if (cmd.rd)
        begin
            rd_key_reg <= key_mem[addr];
            rd_val_reg <= val_mem[addr];
        end
    end

    // arithmetic operands
    assign dy = {y1_reg[VAL_W-1], y1_reg} - {y0_reg[VAL_W-1], y0_reg};
    assign dy_mag = dy[32] ? (~dy + 33'd1) : dy;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            q_reg <= in_key;
            v_reg <= in_val;
        end
        if (cmd.cap_first)
        begin
            kf_reg <= rd_key_reg;
            vf_reg <= rd_val_reg;
        end
        if (cmd.cap_last)
        begin
            kl_reg <= rd_key_reg;
            vl_reg <= rd_val_reg;
        end
        if (cmd.cap_hi)
        begin
            x1_reg <= rd_key_reg;
            y1_reg <= rd_val_reg;
        end
        if (cmd.cap_lo)
        begin
            x0_reg <= rd_key_reg;
            y0_reg <= rd_val_reg;
        end
        if (cmd.div_start)
        begin
            neg_reg <= dy[32];
        end
        prod_reg <= dy_mag[31:0] * (q_reg - x0_reg);
    end

    // counters and search bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg <= '0;
            lo_reg <= '0;
            hi_reg <= '0;
        end
        else
        begin
            if (cmd.cnt_clear)
                count_reg <= '0;
            else if (cmd.cnt_inc)
                count_reg <= count_reg + CW'(1);
            if (cmd.latch_in)
                pos_reg <= count_reg;
            else if (cmd.dec_pos)
                pos_reg <= pos_reg - CW'(1);
            if (cmd.bs_init)
            begin
                lo_reg <= CW'(1);
                hi_reg <= count_reg - CW'(1);
            end
            else if (cmd.bs_step)
            begin
                if (rd_key_reg < q_reg)
                    lo_reg <= mid + CW'(1);
                else
                    hi_reg <= mid;
            end
        end
    end

    tli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (x1_reg - x0_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign out_lo = q_reg < kf_reg;
    assign out_hi = q_reg > kl_reg;

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg <= 1'b0;
        else
            rv_reg <= cmd.emit_zero | cmd.emit_full | cmd.emit_empty |
                      cmd.emit_first | cmd.emit_last | cmd.emit_interp;
    end

    always_ff @(posedge clk)
    begin
        rval_reg <= '0;
        roor_reg <= 1'b0;
        rst_reg <= ST_OK;
        if (cmd.emit_full)
            rst_reg <= ST_FULL;
        else if (cmd.emit_empty)
        begin
            roor_reg <= 1'b1;
            rst_reg <= ST_EMPTY;
        end
        else if (cmd.emit_first || cmd.emit_last)
        begin
            roor_reg <= cmd.emit_first ? out_lo : out_hi;
            if (extrap_mode == MODE_ZERO)
                rval_reg <= '0;
            else if (extrap_mode != MODE_EDGE &&
                     (cmd.emit_first ? out_lo : out_hi))
                rst_reg <= ST_OUTSIDE;
            else
                rval_reg <= cmd.emit_first ? vf_reg : vl_reg;
        end
        else if (cmd.emit_interp)
            rval_reg <= neg_reg ? (y0_reg - quotient[31:0]) : (y0_reg + quotient[31:0]);
    end

    assign res_valid  = rv_reg;
    assign res_value  = rval_reg;
    assign res_oor    = roor_reg;
    assign res_status = rst_reg;

    assign sts.empty      = (count_reg == '0);
    assign sts.full       = (count_reg >= CW'(TABLE_DEPTH));
    assign sts.pos_zero   = (pos_reg == '0);
    assign sts.scan_gt    = (rd_key_reg > q_reg);
    assign sts.bs_done    = !(lo_reg < hi_reg);
    assign sts.q_le_first = (q_reg <= kf_reg);
    assign sts.q_ge_last  = (q_reg >= kl_reg);
    assign sts.div_done   = div_done;

endmodule

// File: hw/rtl/tli_ctrl.sv
// ----------------------------------------------------------------------------
// tli_ctrl
// sequencer for clear, load insertion and query search
// ----------------------------------------------------------------------------
module tli_ctrl
    import tli_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] opcode,
    input  tli_sts_t   sts,
    output logic       busy,
    output tli_cmd_t   cmd
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_DISP   = 14'b00000000000010,
        S_LRD    = 14'b00000000000100,
        S_LCHK   = 14'b00000000001000,
        S_LWR    = 14'b00000000010000,
        S_QRDF   = 14'b00000000100000,
        S_QRDL   = 14'b00000001000000,
        S_QEDGE  = 14'b00000010000000,
        S_BSRD   = 14'b00000100000000,
        S_BSCMP  = 14'b00001000000000,
        S_HIRD   = 14'b00010000000000,
        S_LORD   = 14'b00100000000000,
        S_MUL    = 14'b01000000000000,
        S_DIV    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] op_reg;
    logic [1:0] sub_reg, sub_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= OP_CLEAR;
            sub_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sub_reg <= sub_next;
            if (state_reg == S_IDLE && start)
                op_reg <= opcode;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        sub_next = sub_reg;
        cmd = '0;
        cmd.asel = AS_FIRST;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch_in = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_IDLE;
                case (op_reg)
                    OP_CLEAR:
                    begin
                        cmd.cnt_clear = 1'b1;
                        cmd.emit_zero = 1'b1;
                    end
                    OP_LOAD:
                        if (sts.full)
                            cmd.emit_full = 1'b1;
                        else
                            state_next = S_LRD;
                    OP_QUERY:
                        if (sts.empty)
                            cmd.emit_empty = 1'b1;
                        else
                        begin
                            cmd.asel = AS_FIRST;
                            cmd.rd = 1'b1;
                            state_next = S_QRDF;
                        end
                    default:
                        cmd.emit_zero = 1'b1;
                endcase
            end
            // read entry below the insertion point
            S_LRD:
            begin
                if (sts.pos_zero)
                    state_next = S_LWR;
                else
                begin
                    cmd.asel = AS_LOAD_SCAN;
                    cmd.rd = 1'b1;
                    state_next = S_LCHK;
                end
            end
            // move it up if its key is greater
            S_LCHK:
            begin
                if (sts.scan_gt)
                begin
                    cmd.asel = AS_SHIFT;
                    cmd.wr_shift = 1'b1;
                    cmd.dec_pos = 1'b1;
                    state_next = S_LRD;
                end
                else
                    state_next = S_LWR;
            end
            S_LWR:
            begin
                cmd.asel = AS_SHIFT;
                cmd.wr_new = 1'b1;
                cmd.cnt_inc = 1'b1;
                cmd.emit_zero = 1'b1;
                state_next = S_IDLE;
            end
            S_QRDF:
            begin
                cmd.cap_first = 1'b1;
                cmd.asel = AS_LAST;
                cmd.rd = 1'b1;
                state_next = S_QRDL;
            end
            S_QRDL:
            begin
                cmd.cap_last = 1'b1;
                state_next = S_QEDGE;
            end
            S_QEDGE:
            begin
                cmd.bs_init = 1'b1;
                if (sts.q_le_first)
                begin
                    cmd.emit_first = 1'b1;
                    state_next = S_IDLE;
                end
                else if (sts.q_ge_last)
                begin
                    cmd.emit_last = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_BSRD;
            end
            S_BSRD:
            begin
                if (sts.bs_done)
                begin
                    cmd.asel = AS_LO;
                    cmd.rd = 1'b1;
                    state_next = S_HIRD;
                end
                else
                begin
                    cmd.asel = AS_MID;
                    cmd.rd = 1'b1;
                    state_next = S_BSCMP;
                end
            end
            S_BSCMP:
            begin
                cmd.bs_step = 1'b1;
                state_next = S_BSRD;
            end
            S_HIRD:
            begin
                cmd.cap_hi = 1'b1;
                cmd.asel = AS_LOM1;
                cmd.rd = 1'b1;
                state_next = S_LORD;
            end
            S_LORD:
            begin
                cmd.cap_lo = 1'b1;
                sub_next = '0;
                state_next = S_MUL;
            end
            // product registers after operands settle
            S_MUL:
            begin
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd1)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.emit_interp = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // a request is only taken in idle
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_DISP))
        else $error("accept did not dispatch");
    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == S_DIV))
        else $error("divider done outside divide state");
    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_zero, cmd.emit_full, cmd.emit_empty,
                  cmd.emit_first, cmd.emit_last, cmd.emit_interp}))
        else $error("multiple results in one cycle");

endmodule

// File: hw/rtl/table_linear_interpolator_core.sv
// ----------------------------------------------------------------------------
// table_linear_interpolator_core
// sorted wavelength table with insertion, binary search and interpolation
// ----------------------------------------------------------------------------
// usage: a request is taken when start is high and busy is low; opcode
// selects clear, load or query. exactly one result follows per request on
// result_value, beyond_table and status, marked by done for one cycle; the
// receiver cannot stall.
// sequence: clear, unused opcodes, empty-table queries and rejected loads
// answer directly from dispatch. a load scans down from the top entry,
// moving each greater entry up one place, and stops on a smaller or equal
// key or at the bottom; the single memory port does a read and a write
// for each shifted entry. a query at or outside the ends reads the first
// and last entries and answers; an interior query runs a binary search
// (at most ceil(log2(count-1)) steps), then the 56-step restoring divider.
// busy drops in the cycle done rises, so the next request can be taken at
// the edge that ends it; one request is in flight at a time.
// configuration: apb register 0 at address 0 is extrap_mode; the user must
// write it only while idle, unenforced by the block. pready is always high.
// reset: the entry count clears and extrap_mode returns to edge clamping;
// table contents stay undefined and are never read before written.
// ----------------------------------------------------------------------------
module table_linear_interpolator_core
    import tli_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [KEY_W-1:0]   wavelength,
    input  logic signed [VAL_W-1:0] entry_value,
    output logic               done,
    output logic signed [VAL_W-1:0] result_value,
    output logic               beyond_table,
    output logic [1:0]         status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    tli_cmd_t cmd;
    tli_sts_t sts;
    logic [1:0] mode_reg;
    logic [VAL_W-1:0] rv;

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_EDGE;
        else if (psel && penable && pwrite && paddr == 2'd0)
            mode_reg <= pwdata[1:0];
    end
    assign prdata = (paddr == 2'd0) ? {30'd0, mode_reg} : 32'd0;

    tli_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .sts    (sts),
        .busy   (busy),
        .cmd    (cmd)
    );

    tli_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .extrap_mode        (mode_reg),
        .in_key             (wavelength),
        .in_val             (entry_value),
        .sts                (sts),
        .res_valid          (done),
        .res_value          (rv),
        .res_oor            (beyond_table),
        .res_status         (status)
    );

    assign result_value = rv;

endmodule
